[hdl/npd_pkg.sv]
`default_nettype none

package npd_pkg;

    // Datapath widths.
    localparam int SAMPLE_BITS   = 16;
    localparam int LUT_ADDR_BITS = 10;
    localparam int PHASE_BITS    = 32;
    localparam int TRIG_BITS     = 16;
    localparam int LEN_BITS      = 17;
    localparam int INDEX_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // Table geometry: full wave, built from one octant.
    localparam int LUT_SIZE     = 1 << LUT_ADDR_BITS;
    localparam int QUARTER_SIZE = LUT_SIZE / 4;
    localparam int OCTANT_SIZE  = QUARTER_SIZE / 2;
    localparam real PI_VAL      = 3.1415926535897932384626433832795;
    localparam real LUT_STEP    = PI_VAL / 4.0 / OCTANT_SIZE;
    localparam real TRIG_SCALE  = 32767.0;

    // Longest frame, in samples.
    localparam logic [LEN_BITS-1:0] MAX_FRAME_LEN = LEN_BITS'(1 << INDEX_BITS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FREQ_WORD     = 2'd0,
        CFG_PHASE_WORD    = 2'd1,
        CFG_FRAME_SAMPLES = 2'd2
    } npd_cfg_idx_t;

    typedef logic signed [TRIG_BITS-1:0] npd_tab_t [LUT_SIZE];

    // Table read request and returned cosine and sine pair.
    typedef struct packed {
        logic                     en;
        logic [LUT_ADDR_BITS-1:0] addr;
    } npd_rom_req_t;

    typedef struct packed {
        logic signed [TRIG_BITS-1:0] cos_val;
        logic signed [TRIG_BITS-1:0] sin_val;
    } npd_trig_t;

    // Round a value in [0, 1] scaled by full scale, halves rounded up.
    function automatic logic signed [TRIG_BITS-1:0] npd_scale(input real v);
        int r;
        r = $rtoi(TRIG_SCALE * v + 0.5);
        return TRIG_BITS'(r);
    endfunction

    // Build the cosine or sine table at elaboration from one octant.
    function automatic npd_tab_t npd_make_tab(input logic want_sin);
        npd_tab_t tab;
        int quad;
        int j;
        int m;
        real x;
        logic signed [TRIG_BITS-1:0] sr;
        logic signed [TRIG_BITS-1:0] cr;
        logic signed [TRIG_BITS-1:0] sv;
        logic signed [TRIG_BITS-1:0] cv;
        for (int k = 0; k < LUT_SIZE; k++) begin
            quad = k >> (LUT_ADDR_BITS - 2);
            j    = k & (QUARTER_SIZE - 1);
            m    = (j <= OCTANT_SIZE) ? j : QUARTER_SIZE - j;
            x    = m * LUT_STEP;
            if (j <= OCTANT_SIZE) begin
                sr = npd_scale($sin(x));
                cr = npd_scale($cos(x));
            end
            else begin
                sr = npd_scale($cos(x));
                cr = npd_scale($sin(x));
            end
            case (quad)
                0: begin
                    sv = sr;
                    cv = cr;
                end
                1: begin
                    sv = cr;
                    cv = -sr;
                end
                2: begin
                    sv = -sr;
                    cv = -cr;
                end
                default: begin
                    sv = -cr;
                    cv = sr;
                end
            endcase
            tab[k] = want_sin ? sv : cv;
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

[hdl/nco_phase_derotator.sv]
// Channel    Direction  Transaction carries
// s_axis     in         tdata: in_i [15:0], in_q [31:16]
// m_axis     out        tdata: out_i [15:0], out_q [31:16]; tlast: frame_last
// cfg        in         cfg_index: register (0 freq, 1 phase, 2 frame length); cfg_data
//
// One sample is accepted per clock while the pipeline is not stalled; each passes through
// table read, four products, then sum, round and saturate.
// Every stage has its own valid bit, so empty stages are filled while the output stalls.
// Reset clears the phase accumulator, the sample index and the stage valid bits.
// The configuration port always accepts; freq 0, phase 0 and frame length 1024 after reset.
`default_nettype none

module nco_phase_derotator
    import npd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // in_i [15:0], in_q [31:16]
    input  wire logic [2*SAMPLE_BITS-1:0] s_axis_tdata,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // out_i [15:0], out_q [31:16]
    output logic [2*SAMPLE_BITS-1:0]      m_axis_tdata,
    // frame_last
    output logic                          m_axis_tlast,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int PROD_BITS = SAMPLE_BITS + TRIG_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int RND_BITS  = SUM_BITS - 15;

    // Configuration registers.
    logic [PHASE_BITS-1:0] freq_word_reg;
    logic [PHASE_BITS-1:0] phase_word_reg;
    logic [LEN_BITS-1:0]   frame_samples_reg;

    // Oscillator state.
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [INDEX_BITS-1:0] sample_index_reg;

    // Pipeline registers.
    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [SAMPLE_BITS-1:0] i1_reg, q1_reg;
    logic                          last1_reg, last2_reg;
    logic signed [PROD_BITS-1:0]   ic_reg, qs_reg, qc_reg, is_reg;
    logic [SAMPLE_BITS-1:0]        out_i_reg, out_q_reg;
    logic                          last3_reg;

    logic                  r1, r2, r3;
    logic                  s_fire;
    logic [LEN_BITS-1:0]   last_pos;
    logic                  last_now;
    logic [PHASE_BITS-1:0] theta;
    npd_rom_req_t          rom_req;
    npd_trig_t             trig;
    logic signed [SUM_BITS-1:0] sum_i, sum_q;

    // Round to nearest with ties up, then saturate to the sample range.
    function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [SUM_BITS-1:0] s);
        logic signed [SUM_BITS-1:0] biased;
        logic signed [RND_BITS-1:0] r;
        logic signed [RND_BITS-1:0] max_v;
        logic signed [RND_BITS-1:0] min_v;
        biased = s + SUM_BITS'(16384);
        r      = RND_BITS'(biased >>> 15);
        max_v  = RND_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
        min_v  = -max_v - RND_BITS'(1);
        if (r > max_v)
            return SAMPLE_BITS'(max_v);
        else if (r < min_v)
            return SAMPLE_BITS'(min_v);
        else
            return r[SAMPLE_BITS-1:0];
    endfunction

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_word_reg     <= '0;
            phase_word_reg    <= '0;
            frame_samples_reg <= LEN_BITS'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FREQ_WORD:     freq_word_reg     <= cfg_data[PHASE_BITS-1:0];
                CFG_PHASE_WORD:    phase_word_reg    <= cfg_data[PHASE_BITS-1:0];
                CFG_FRAME_SAMPLES: frame_samples_reg <= cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Stage readiness: a stage takes new data when empty or when it moves on.
    assign r3            = !v3_reg || m_axis_tready;
    assign r2            = !v2_reg || r3;
    assign r1            = !v1_reg || r2;
    assign s_axis_tready = r1;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Frame position: zero length acts as one, lengths past the maximum clamp.
    always_comb
    begin
        if (frame_samples_reg == '0)
            last_pos = '0;
        else if (frame_samples_reg > MAX_FRAME_LEN)
            last_pos = MAX_FRAME_LEN - LEN_BITS'(1);
        else
            last_pos = frame_samples_reg - LEN_BITS'(1);
    end

    assign last_now = {1'b0, sample_index_reg} >= last_pos;
    assign theta    = (sample_index_reg == '0) ? phase_word_reg : phase_acc_reg;

    // Phase accumulator and sample index advance with each input transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
        end
        else if (s_fire)
        begin
            phase_acc_reg    <= theta + freq_word_reg;
            sample_index_reg <= last_now ? '0 : sample_index_reg + INDEX_BITS'(1);
        end
    end

    // Stage 1: cosine and sine table read alongside the captured sample.
    assign rom_req.en   = s_fire;
    assign rom_req.addr = theta[PHASE_BITS-1 -: LUT_ADDR_BITS];

    npd_rom u_rom
    (
        .clk  (clk),
        .req  (rom_req),
        .trig (trig)
    );

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            i1_reg    <= s_axis_tdata[SAMPLE_BITS-1:0];
            q1_reg    <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            last1_reg <= last_now;
        end
    end

    // Stage 2: the four products.
    always_ff @(posedge clk)
    begin
        if (v1_reg && r2)
        begin
            ic_reg    <= i1_reg * trig.cos_val;
            qs_reg    <= q1_reg * trig.sin_val;
            qc_reg    <= q1_reg * trig.cos_val;
            is_reg    <= i1_reg * trig.sin_val;
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: sums, rounding and saturation into the output register.
    assign sum_i = SUM_BITS'(ic_reg) + SUM_BITS'(qs_reg);
    assign sum_q = SUM_BITS'(qc_reg) - SUM_BITS'(is_reg);

    always_ff @(posedge clk)
    begin
        if (v2_reg && r3)
        begin
            out_i_reg <= round_sat(sum_i);
            out_q_reg <= round_sat(sum_q);
            last3_reg <= last2_reg;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= s_axis_tvalid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {out_q_reg, out_i_reg};
    assign m_axis_tlast  = last3_reg;

    // The index restarts after the last sample of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && last_now |=> sample_index_reg == '0)
        else $error("sample index did not restart after frame end");

    // A frame start loads the phase offset before adding the frequency word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && sample_index_reg == '0 |=>
            phase_acc_reg == $past(phase_word_reg + freq_word_reg))
        else $error("phase accumulator not reloaded at frame start");

    // With every stage full and the output stalled, no input may be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted into a full pipeline");

endmodule

`default_nettype wire

[hdl/npd_rom.sv]
`default_nettype none

module npd_rom
    import npd_pkg::*;
(
    input  wire logic         clk,
    input  wire npd_rom_req_t req,
    output npd_trig_t         trig
);

    localparam npd_tab_t COS_TAB = npd_make_tab(1'b0);
    localparam npd_tab_t SIN_TAB = npd_make_tab(1'b1);

    npd_trig_t trig_reg;

    // Registered table read; the data holds while no read is requested.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            trig_reg.cos_val <= COS_TAB[req.addr];
            trig_reg.sin_val <= SIN_TAB[req.addr];
        end
    end

    assign trig = trig_reg;

endmodule

`default_nettype wire

[dv/nco_phase_derotator_tb.sv]
`default_nettype none

module nco_phase_derotator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import npd_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PIPE_FLUSH   = 6;
    localparam int MAX_REPORTS  = 10;

    // pi/4 in Q62 fixed point, used to build the oscillator tables.
    localparam logic [63:0] PI_QUARTER_Q62 = 64'h3243F6A8885A308D;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] q;
        logic signed [SAMPLE_BITS-1:0] i;
    } iq_sample_t;

    typedef struct packed {
        logic       last;
        iq_sample_t iq;
    } rotated_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic [2*SAMPLE_BITS-1:0] s_axis_tdata = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [2*SAMPLE_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    npd_cfg_idx_t             cfg_index = CFG_FREQ_WORD;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Oscillator tables and the predicted state of the mixer.
    logic signed [15:0]       cos_rom [LUT_SIZE];
    logic signed [15:0]       sin_rom [LUT_SIZE];
    logic [PHASE_BITS-1:0]    nco_acc = '0;
    logic [15:0]              frame_pos = '0;
    logic [31:0]              cfg_freq = '0;
    logic [31:0]              cfg_phase = '0;
    logic [LEN_BITS-1:0]      cfg_frame_len = LEN_BITS'(1024);

    iq_sample_t               sample_q[$];
    rotated_t                 rotation_q[$];
    rotated_t                 mon_got;
    rotated_t                 mon_want;

    // Sender burst shaping and receiver stall pattern.
    int                       burst_left = 0;
    int                       gap_left = 0;
    logic                     gaps_on = 1'b0;
    logic                     stalls_on = 1'b0;
    logic [15:0]              rx_pattern = 16'hFFFF;
    logic [3:0]               stall_pos = '0;

    int                       err_count = 0;
    int                       result_count = 0;
    int                       frame_ends = 0;
    int                       cfg_writes = 0;
    int                       cycle_count = 0;
    int                       random_sent = 0;
    int                       phase_num = 0;
    int                       batch_len;
    int unsigned              wr_mask;
    logic [31:0]              pick;

    nco_phase_derotator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Q62 product, keeping the Q62 part.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Scale a Q62 value in [0, 1] to full scale, halves rounded up.
    function automatic int q62_to_trig(input logic [63:0] v);
        logic [127:0] p;
        p = 128'd32767 * {64'd0, v} + (128'd1 << 61);
        return int'(p[93:62]);
    endfunction

    // Build both tables from one octant with integer Taylor series.
    function automatic void build_trig_tables();
        int           quarter;
        int           quad;
        int           j;
        int           m;
        int           k;
        int           n;
        int           sr;
        int           cr;
        int           sv;
        int           cv;
        logic [127:0] p;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  ts;
        logic [63:0]  tc;
        logic [63:0]  ss;
        logic [63:0]  cs;
        logic [63:0]  dv;
        quarter = LUT_SIZE / 4;
        for (k = 0; k < LUT_SIZE; k++)
        begin
            quad = k >> (LUT_ADDR_BITS - 2);
            j    = k & (quarter - 1);
            m    = (j <= quarter / 2) ? j : quarter - j;
            p    = {64'd0, PI_QUARTER_Q62} * 128'(m);
            x    = p[LUT_ADDR_BITS-3 +: 64];
            x2   = q62_mul(x, x);
            ts   = x;
            ss   = x;
            tc   = 64'd1 << 62;
            cs   = tc;
            for (n = 1; n <= 14; n++)
            begin
                dv = 64'((2 * n - 1) * (2 * n));
                tc = q62_mul(tc, x2) / dv;
                dv = 64'((2 * n) * (2 * n + 1));
                ts = q62_mul(ts, x2) / dv;
                if (n % 2 == 1)
                begin
                    cs -= tc;
                    ss -= ts;
                end
                else
                begin
                    cs += tc;
                    ss += ts;
                end
            end
            // Past the quadrant midpoint sine and cosine swap roles.
            if (j <= quarter / 2)
            begin
                sr = q62_to_trig(ss);
                cr = q62_to_trig(cs);
            end
            else
            begin
                sr = q62_to_trig(cs);
                cr = q62_to_trig(ss);
            end
            case (quad)
                0:
                begin
                    sv = sr;
                    cv = cr;
                end
                1:
                begin
                    sv = cr;
                    cv = -sr;
                end
                2:
                begin
                    sv = -sr;
                    cv = -cr;
                end
                default:
                begin
                    sv = -cr;
                    cv = sr;
                end
            endcase
            sin_rom[k] = 16'(sv);
            cos_rom[k] = 16'(cv);
        end
    endfunction

    // Drop 15 fraction bits with round half up, then clamp to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] round_q15(input longint sum);
        longint r;
        longint max_val;
        max_val = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        r = (sum + 64'sd16384) >>> 15;
        if (r > max_val)
            r = max_val;
        else if (r < -max_val - 1)
            r = -max_val - 1;
        return r[SAMPLE_BITS-1:0];
    endfunction

    // Rotate one accepted sample by minus the oscillator phase and queue the result.
    function automatic void predict_rotation(input iq_sample_t x);
        int unsigned              len;
        logic [LUT_ADDR_BITS-1:0] addr;
        longint                   c;
        longint                   s;
        longint                   xi;
        longint                   xq;
        rotated_t                 y;
        if (cfg_frame_len == 0)
            len = 1;
        else if (cfg_frame_len > MAX_FRAME_LEN)
            len = MAX_FRAME_LEN;
        else
            len = cfg_frame_len;
        if (frame_pos == 0)
            nco_acc = cfg_phase;
        addr    = nco_acc[PHASE_BITS-1 -: LUT_ADDR_BITS];
        c       = cos_rom[addr];
        s       = sin_rom[addr];
        xi      = x.i;
        xq      = x.q;
        y.iq.i  = round_q15(xi * c + xq * s);
        y.iq.q  = round_q15(xq * c - xi * s);
        y.last  = (frame_pos >= len - 1);
        rotation_q.push_back(y);
        nco_acc = nco_acc + cfg_freq;
        frame_pos = y.last ? 16'd0 : frame_pos + 16'd1;
    endfunction

    function automatic void add_sample(input int i_val, input int q_val);
        iq_sample_t x;
        x.i = 16'(i_val);
        x.q = 16'(q_val);
        sample_q.push_back(x);
    endfunction

    function automatic int edge_value();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // Register write transaction; the predicted settings follow the write.
    task automatic write_reg(input npd_cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FREQ_WORD:     cfg_freq = data;
            CFG_PHASE_WORD:    cfg_phase = data;
            CFG_FRAME_SAMPLES: cfg_frame_len = data[LEN_BITS-1:0];
            default:           ;
        endcase
        cfg_writes++;
    endtask

    // Hold off until every queued sample is sent and every result has arrived.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || rotation_q.size() != 0 || s_axis_tvalid);
        repeat (PIPE_FLUSH) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: bursts of random length, separated by random gaps when gaps are on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(sample_q.pop_front());
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sample_q[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= gaps_on ? $urandom_range(0, 6) : 0;
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a rotating stall pattern when stalls are on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_pos     <= '0;
        end
        else
        begin
            stall_pos     <= stall_pos + 4'd1;
            m_axis_tready <= !stalls_on || rx_pattern[stall_pos];
        end
    end

    // Monitor: check each output transaction, then predict from each input transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                mon_got.iq   = m_axis_tdata;
                mon_got.last = m_axis_tlast;
                result_count++;
                if (mon_got.last)
                    frame_ends++;
                if (rotation_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("Unexpected result: i=%0d q=%0d last=%0b",
                                 mon_got.iq.i, mon_got.iq.q, mon_got.last);
                end
                else
                begin
                    mon_want = rotation_q.pop_front();
                    if (mon_got.iq.i !== mon_want.iq.i || mon_got.iq.q !== mon_want.iq.q ||
                        mon_got.last !== mon_want.last)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("Mismatch on result %0d: expected i=%0d q=%0d last=%0b,",
                                     result_count, mon_want.iq.i, mon_want.iq.q,
                                     mon_want.last, " got i=%0d q=%0d last=%0b",
                                     mon_got.iq.i, mon_got.iq.q, mon_got.last);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_rotation(iq_sample_t'(s_axis_tdata));
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        build_trig_tables();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: full-scale inputs on each axis at zero phase.
        @(negedge clk);
        add_sample(32767, 0);
        add_sample(-32768, 0);
        add_sample(0, 32767);
        add_sample(0, -32768);
        wait_idle();

        // Zero frame length ends every frame; the 45 degree phase drives saturation.
        write_reg(CFG_FREQ_WORD, 32'h0000_0000);
        write_reg(CFG_PHASE_WORD, 32'h2000_0000);
        write_reg(CFG_FRAME_SAMPLES, 32'h0000_0000);
        @(negedge clk);
        add_sample(32767, 32767);
        add_sample(-32768, -32768);
        add_sample(-32768, 32767);
        add_sample(32767, -32768);
        add_sample(0, 0);
        wait_idle();

        // All-ones words; the frame length clamps to its maximum.
        write_reg(CFG_FREQ_WORD, 32'hFFFF_FFFF);
        write_reg(CFG_PHASE_WORD, 32'hFFFF_FFFF);
        write_reg(CFG_FRAME_SAMPLES, 32'hFFFF_FFFF);
        @(negedge clk);
        add_sample(-32768, 32767);
        add_sample(32767, 32767);
        add_sample(-1, -1);
        add_sample(1, -32768);
        wait_idle();

        // Short frames under back-pressure, then shorten the frame mid-way.
        write_reg(CFG_FREQ_WORD, 32'h1234_5678);
        write_reg(CFG_PHASE_WORD, 32'h0ABC_DEF0);
        write_reg(CFG_FRAME_SAMPLES, 32'd10);
        @(negedge clk);
        gaps_on    = 1'b1;
        stalls_on  = 1'b1;
        rx_pattern = 16'h5A3C;
        repeat (9) add_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
        wait_idle();
        write_reg(CFG_FRAME_SAMPLES, 32'd2);
        @(negedge clk);
        repeat (3) add_sample(edge_value(), $urandom_range(0, 65535));
        wait_idle();

        // Random phases, each with fresh settings and its own idling pattern.
        while (random_sent < RANDOM_ITEMS)
        begin
            wr_mask = $urandom_range(1, 7);
            if (wr_mask[0])
            begin
                case ($urandom_range(0, 4))
                    0:       pick = 32'h0000_0000;
                    1:       pick = 32'hFFFF_FFFF;
                    2:       pick = $urandom_range(0, 1 << 24);
                    default: pick = $urandom;
                endcase
                write_reg(CFG_FREQ_WORD, pick);
            end
            if (wr_mask[1])
            begin
                case ($urandom_range(0, 3))
                    0:       pick = 32'h0000_0000;
                    1:       pick = 32'hFFFF_FFFF;
                    default: pick = $urandom;
                endcase
                write_reg(CFG_PHASE_WORD, pick);
            end
            if (wr_mask[2])
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: pick = $urandom_range(1, 40);
                    4:          pick = 32'd0;
                    5:          pick = 32'd65536;
                    6:          pick = $urandom;
                    default:    pick = $urandom_range(41, 2000);
                endcase
                write_reg(CFG_FRAME_SAMPLES, pick);
            end
            @(negedge clk);
            gaps_on    = (phase_num == 1) || (phase_num != 0 && $urandom_range(0, 2) != 0);
            stalls_on  = (phase_num == 1) || (phase_num != 0 && $urandom_range(0, 2) != 0);
            rx_pattern = 16'($urandom) | (16'h0001 << $urandom_range(0, 15));
            batch_len  = $urandom_range(60, 170);
            repeat (batch_len)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_sample(edge_value(), edge_value());
                else
                    add_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            random_sent += batch_len;
            phase_num++;
            wait_idle();
        end

        repeat (PIPE_FLUSH) @(posedge clk);
        $display("Rotated %0d samples (%0d frame ends) over the directed cases",
                 result_count, frame_ends, " and %0d random phases.", phase_num);
        $display("Made %0d register writes, frame lengths zero to full, with and without stalls.",
                 cfg_writes);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/npd_pkg.sv
hdl/npd_rom.sv
hdl/nco_phase_derotator.sv
dv/nco_phase_derotator_tb.sv
